/* design/etm_pkg.sv */
// ----------------------------------------------------------------------------
// etm_pkg: shared types, constants and tables for the emoji token matcher
// Emoji code points, shortcode names and small helper functions.
// ----------------------------------------------------------------------------
package etm_pkg;

  localparam int unsigned TABLE_ENTRIES = 42;
  localparam int unsigned NAME_LIMIT    = 31;
  localparam int unsigned NAME_BYTES    = 32;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned CP_W          = 21;
  localparam int unsigned UNIT_W        = 16;

  localparam logic [UNIT_W-1:0] UNIT_NUL   = 16'h0000;
  localparam logic [UNIT_W-1:0] UNIT_COLON = 16'h003A;
  localparam logic [UNIT_W-1:0] ASCII_MAX  = 16'h007F;
  localparam logic [UNIT_W-1:0] HI_SUR_MIN = 16'hD800;
  localparam logic [UNIT_W-1:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [UNIT_W-1:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;

  localparam logic [LEN_W-1:0] LEN_BMP  = 6'd1;
  localparam logic [LEN_W-1:0] LEN_PAIR = 6'd2;
  localparam logic [LEN_W-1:0] LEN_WRAP = 6'd2;  // the two colons

  typedef logic [NAME_BYTES*8-1:0]    name_t;
  typedef logic [TABLE_ENTRIES-1:0]   entry_vec_t;

  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] entry_index;
    logic [LEN_W-1:0] match_length;
    logic             any_match;
    logic             ends_text;
  } result_t;

  localparam logic [CP_W-1:0] EMO_CP [TABLE_ENTRIES] = '{
    21'h1F600, 21'h1F602, 21'h1F923, 21'h1F622, 21'h1F62E, 21'h1F621, 21'h1F60E,
    21'h1F44D, 21'h1F44E, 21'h02764, 21'h1F494, 21'h1F525, 21'h1F480, 21'h1F389,
    21'h1F44F, 21'h1F64F, 21'h02705, 21'h0274C, 21'h1F642, 21'h1F641, 21'h1F609,
    21'h1F61B, 21'h1F31A, 21'h026A0, 21'h1F601, 21'h1F60A, 21'h1F60D, 21'h1F618,
    21'h1F62D, 21'h1F631, 21'h1F914, 21'h1F644, 21'h1F440, 21'h1F4AF, 21'h1F91D,
    21'h1F44B, 21'h1F4AA, 21'h1F926, 21'h1F973, 21'h1F4A9, 21'h1F451, 21'h1F3AE
  };

  // String literals: first character sits in the highest used byte.
  localparam name_t EMO_NAME_RAW [TABLE_ENTRIES] = '{
    "grinning", "joy", "rofl", "cry", {"open", "_mouth"}, "rage", "sunglasses",
    "thumbsup", "thumbsdown", "heart", {"broken_", "heart"}, "fire", "skull",
    "tada", "clap", "pray", "white_check_mark", "x",
    {"slightly_smiling", "_face"}, {"slightly_frowning", "_face"}, "wink",
    {"stuck_out", "_tongue"}, {"new_moon", "_face"}, "warning", "smile", "blush",
    {"heart", "_eyes"}, {"kissing", "_heart"}, "sob", "scream", "thinking",
    {"roll", "_eyes"},
    "eyes", "100", "handshake", "wave", "muscle", "facepalm",
    {"partying", "_face"}, "poop", "crown", "video_game"
  };

  function automatic logic [CNT_W-1:0] name_len(name_t raw);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int j = 0; j < NAME_BYTES; j++) begin
      if (raw[j*8 +: 8] != 8'h00) n = CNT_W'(j + 1);
    end
    return n;
  endfunction

  // Reorder so that character p of the name sits in byte p; unused bytes are zero.
  function automatic name_t fwd_name(name_t raw);
    name_t       f;
    int unsigned n;
    f = '0;
    n = int'(name_len(raw));
    for (int j = 0; j < NAME_BYTES; j++) begin
      if (j < n) f[j*8 +: 8] = raw[(n-1-j)*8 +: 8];
    end
    return f;
  endfunction

  function automatic logic [IDX_W-1:0] lowest_idx(entry_vec_t v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

/* design/emoji_token_matcher.sv */
// ----------------------------------------------------------------------------
// emoji_token_matcher: streaming emoji recognizer over UTF-16 code units
// Reports BMP code points, surrogate pairs and :shortcode: names that match.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one UTF-16 code unit and a
//   text_end flag per request. Output channel (out_valid_o/out_ready_i) gives
//   one result per input request, in order.
//   A request's result is registered into the result register when the output
//   is not stalled, else into the skid register. Throughput is one request per
//   cycle while in_ready_o is high; all matching is a single parallel compare
//   against the 42-entry table between the input and the result register.
//   A two-deep output (result register plus skid register) lets the input
//   take one more request after the receiver stalls; in_ready_o drops
//   only while the skid register is full.
//   cfg_we_i writes the entry present mask; reset sets it to all ones.
//   Reset clears all matcher state and empties the output. A zero code unit
//   or a request with text_end set clears the matcher state afterwards.
// ----------------------------------------------------------------------------
module emoji_token_matcher (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [etm_pkg::TABLE_ENTRIES-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [etm_pkg::UNIT_W-1:0]          code_unit_i,
  input  logic                                text_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                matched_o,
  output logic [etm_pkg::IDX_W-1:0]           entry_index_o,
  output logic [etm_pkg::LEN_W-1:0]           match_length_o,
  output logic                                any_match_o,
  output logic                                ends_text_o
);

  etm_pkg::entry_vec_t mask_q;

  logic [9:0]                 pending_high_q, pending_high_d;
  logic                       pending_valid_q, pending_valid_d;
  logic                       colon_open_q, colon_open_d;
  etm_pkg::entry_vec_t        alive_q, alive_d;
  logic [etm_pkg::CNT_W-1:0]  name_count_q, name_count_d;
  logic                       seen_q, seen_d;

  etm_pkg::result_t           res_d, out_q, skid_q;
  logic                       out_valid_q, skid_valid_q;

  logic                       in_fire;
  logic                       lo_sur, hi_sur, is_colon, is_nul, kill;
  logic [etm_pkg::CP_W-1:0]   cp_cand;
  etm_pkg::entry_vec_t        cp_hit, name_hit, keep;

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;

  assign is_nul   = (code_unit_i == etm_pkg::UNIT_NUL);
  assign is_colon = (code_unit_i == etm_pkg::UNIT_COLON);
  assign hi_sur   = (code_unit_i >= etm_pkg::HI_SUR_MIN) && (code_unit_i <= etm_pkg::HI_SUR_MAX);
  assign lo_sur   = pending_valid_q &&
                    (code_unit_i >= etm_pkg::LO_SUR_MIN) && (code_unit_i <= etm_pkg::LO_SUR_MAX);
  assign kill     = (code_unit_i > etm_pkg::ASCII_MAX) ||
                    (colon_open_q && (name_count_q >= etm_pkg::CNT_W'(etm_pkg::NAME_LIMIT)));

  // surrogate pair decode: base + high ten bits + low ten bits
  assign cp_cand = lo_sur ? (etm_pkg::SUPP_BASE + {1'b0, pending_high_q, code_unit_i[9:0]})
                          : {{(etm_pkg::CP_W-etm_pkg::UNIT_W){1'b0}}, code_unit_i};

  for (genvar g = 0; g < etm_pkg::TABLE_ENTRIES; g++) begin : g_entry
    localparam etm_pkg::name_t NameFwd = etm_pkg::fwd_name(etm_pkg::EMO_NAME_RAW[g]);
    localparam logic [etm_pkg::CNT_W-1:0] NameLen = etm_pkg::name_len(etm_pkg::EMO_NAME_RAW[g]);

    assign cp_hit[g]   = (cp_cand == etm_pkg::EMO_CP[g]) & mask_q[g];
    assign name_hit[g] = alive_q[g] & mask_q[g] & (name_count_q == NameLen);
    // zero padding past the name end never equals a live (nonzero) unit
    assign keep[g]     = alive_q[g] &
                         (NameFwd[name_count_q[4:0]*8 +: 8] == code_unit_i[7:0]);
  end

  always_comb begin
    pending_high_d  = pending_high_q;
    pending_valid_d = pending_valid_q;
    colon_open_d    = colon_open_q;
    alive_d         = alive_q;
    name_count_d    = name_count_q;
    seen_d          = seen_q;
    res_d           = '0;
    res_d.ends_text = text_end_i;

    if (is_nul) begin
      res_d.any_match = seen_q;
    end else begin
      if (|cp_hit) begin
        res_d.matched      = 1'b1;
        res_d.entry_index  = etm_pkg::lowest_idx(cp_hit);
        res_d.match_length = lo_sur ? etm_pkg::LEN_PAIR : etm_pkg::LEN_BMP;
      end

      if (lo_sur) begin
        pending_valid_d = 1'b0;
        pending_high_d  = '0;
      end else if (hi_sur) begin
        pending_valid_d = 1'b1;
        pending_high_d  = code_unit_i[9:0];
      end else begin
        pending_valid_d = 1'b0;
        pending_high_d  = '0;
      end

      if (is_colon) begin
        if (colon_open_q && (name_count_q != '0) && (|name_hit)) begin
          res_d.matched      = 1'b1;
          res_d.entry_index  = etm_pkg::lowest_idx(name_hit);
          res_d.match_length = name_count_q + etm_pkg::LEN_WRAP;
        end
        colon_open_d = 1'b1;
        alive_d      = '1;
        name_count_d = '0;
      end else if (kill) begin
        colon_open_d = 1'b0;
        alive_d      = '0;
        name_count_d = '0;
      end else if (colon_open_q) begin
        alive_d      = keep;
        name_count_d = name_count_q + etm_pkg::CNT_W'(1);
      end

      seen_d          = seen_q | res_d.matched;
      res_d.any_match = seen_d;
    end

    if (is_nul || text_end_i) begin
      pending_high_d  = '0;
      pending_valid_d = 1'b0;
      colon_open_d    = 1'b0;
      alive_d         = '0;
      name_count_d    = '0;
      seen_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_high_q  <= '0;
      pending_valid_q <= 1'b0;
      colon_open_q    <= 1'b0;
      alive_q         <= '0;
      name_count_q    <= '0;
      seen_q          <= 1'b0;
    end else if (in_fire) begin
      pending_high_q  <= pending_high_d;
      pending_valid_q <= pending_valid_d;
      colon_open_q    <= colon_open_d;
      alive_q         <= alive_d;
      name_count_q    <= name_count_d;
      seen_q          <= seen_d;
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res_d;
      end
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign matched_o      = out_q.matched;
  assign entry_index_o  = out_q.entry_index;
  assign match_length_o = out_q.match_length;
  assign any_match_o    = out_q.any_match;
  assign ends_text_o    = out_q.ends_text;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register empty");

  a_match_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && matched_o) |-> (match_length_o != '0) && any_match_o)
    else $error("match reported without length or running flag");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o) |-> (entry_index_o == '0) && (match_length_o == '0))
    else $error("index or length nonzero without a match");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (text_end_i || code_unit_i == etm_pkg::UNIT_NUL)) |=>
      !colon_open_q && !pending_valid_q && !seen_q && (name_count_q == '0))
    else $error("state not cleared after end of text");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    name_count_q <= etm_pkg::CNT_W'(etm_pkg::NAME_LIMIT))
    else $error("shortcode count above limit");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the emoji token matcher
// Streams directed and random UTF-16 text through the block under random
// handshake gaps and checks every result against an in-bench predictor that
// tracks surrogate pairs, shortcode candidates and the running match flag.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SYM       = 42;
  localparam int CODE_MAX    = 31;
  localparam int STALL_LIMIT = 5000;
  localparam int FREEZE_LEN  = 60;

  localparam logic [20:0] sym_point [N_SYM] = '{
    21'h1F600, 21'h1F602, 21'h1F923, 21'h1F622, 21'h1F62E, 21'h1F621, 21'h1F60E,
    21'h1F44D, 21'h1F44E, 21'h02764, 21'h1F494, 21'h1F525, 21'h1F480, 21'h1F389,
    21'h1F44F, 21'h1F64F, 21'h02705, 21'h0274C, 21'h1F642, 21'h1F641, 21'h1F609,
    21'h1F61B, 21'h1F31A, 21'h026A0, 21'h1F601, 21'h1F60A, 21'h1F60D, 21'h1F618,
    21'h1F62D, 21'h1F631, 21'h1F914, 21'h1F644, 21'h1F440, 21'h1F4AF, 21'h1F91D,
    21'h1F44B, 21'h1F4AA, 21'h1F926, 21'h1F973, 21'h1F4A9, 21'h1F451, 21'h1F3AE
  };

  // entries whose code point sits in the BMP
  localparam int bmp_pick [4] = '{9, 16, 17, 23};

  string sym_label [N_SYM] = '{
    "grinning", "joy", "rofl", "cry", {"open", "_mouth"}, "rage", "sunglasses",
    "thumbsup", "thumbsdown", "heart", {"broken_", "heart"}, "fire", "skull",
    "tada", "clap", "pray", "white_check_mark", "x",
    {"slightly_smiling", "_face"}, {"slightly_frowning", "_face"}, "wink",
    {"stuck_out", "_tongue"}, {"new_moon", "_face"}, "warning", "smile", "blush",
    {"heart", "_eyes"}, {"kissing", "_heart"}, "sob", "scream", "thinking",
    {"roll", "_eyes"},
    "eyes", "100", "handshake", "wave", "muscle", "facepalm",
    {"partying", "_face"}, "poop", "crown", "video_game"
  };

  typedef struct {
    logic [etm_pkg::UNIT_W-1:0] unit;
    logic                       fin;
  } text_req_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              cfg_we_i       = 1'b0;
  logic [etm_pkg::TABLE_ENTRIES-1:0] cfg_wdata_i    = '0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_ready_o;
  logic [etm_pkg::UNIT_W-1:0]        code_unit_i    = '0;
  logic                              text_end_i     = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i    = 1'b0;
  logic                              matched_o;
  logic [etm_pkg::IDX_W-1:0]         entry_index_o;
  logic [etm_pkg::LEN_W-1:0]         match_length_o;
  logic                              any_match_o;
  logic                              ends_text_o;

  emoji_token_matcher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_unit_i    (code_unit_i),
    .text_end_i     (text_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .matched_o      (matched_o),
    .entry_index_o  (entry_index_o),
    .match_length_o (match_length_o),
    .any_match_o    (any_match_o),
    .ends_text_o    (ends_text_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  text_req_t         unit_q[$];
  text_req_t         text_buf[$];
  etm_pkg::result_t  match_q[$];

  int send_idle_pct = 21;
  int recv_idle_pct = 86;
  int freeze_req    = 0;
  int freeze_seen   = 0;
  int freeze_left   = 0;
  int err_cnt       = 0;
  int sent_cnt      = 0;
  int quiet_cycles  = 0;

  // predictor state
  etm_pkg::entry_vec_t       mask_shadow = '1;
  logic [9:0]                hi_half     = '0;
  logic                      hi_held     = 1'b0;
  logic                      in_code     = 1'b0;
  etm_pkg::entry_vec_t       code_live   = '0;
  logic [etm_pkg::CNT_W-1:0] code_len    = '0;
  logic                      hit_seen    = 1'b0;

  function automatic void clear_text();
    hi_half   = '0;
    hi_held   = 1'b0;
    in_code   = 1'b0;
    code_live = '0;
    code_len  = '0;
    hit_seen  = 1'b0;
  endfunction

  function automatic int find_point(logic [20:0] cp);
    for (int i = 0; i < N_SYM; i++) begin
      if (sym_point[i] == cp && mask_shadow[i]) return i;
    end
    return -1;
  endfunction

  task automatic scan_unit(input logic [etm_pkg::UNIT_W-1:0] u, input logic fin,
                           output etm_pkg::result_t r);
    logic [20:0]         cp;
    etm_pkg::entry_vec_t keep;
    int                  hit_i;
    r = '0;
    r.ends_text = fin;
    if (u == etm_pkg::UNIT_NUL) begin
      r.any_match = hit_seen;
      clear_text();
      return;
    end
    if (hi_held && u >= etm_pkg::LO_SUR_MIN && u <= etm_pkg::LO_SUR_MAX) begin
      cp = etm_pkg::SUPP_BASE + 21'({hi_half, u[9:0]});
      hit_i = find_point(cp);
      if (hit_i >= 0) begin
        r.matched      = 1'b1;
        r.entry_index  = etm_pkg::IDX_W'(hit_i);
        r.match_length = etm_pkg::LEN_PAIR;
      end
      hi_held = 1'b0;
      hi_half = '0;
    end else begin
      hit_i = find_point(21'(u));
      if (hit_i >= 0) begin
        r.matched      = 1'b1;
        r.entry_index  = etm_pkg::IDX_W'(hit_i);
        r.match_length = etm_pkg::LEN_BMP;
      end
      hi_held = (u >= etm_pkg::HI_SUR_MIN && u <= etm_pkg::HI_SUR_MAX);
      hi_half = hi_held ? u[9:0] : '0;
    end
    if (u == etm_pkg::UNIT_COLON) begin
      // a colon closes the open name first, then starts a fresh one
      if (in_code && code_len > 0) begin
        for (int i = 0; i < N_SYM; i++) begin
          if (code_live[i] && mask_shadow[i] && sym_label[i].len() == int'(code_len)) begin
            r.matched      = 1'b1;
            r.entry_index  = etm_pkg::IDX_W'(i);
            r.match_length = etm_pkg::LEN_W'(code_len + 2);
            break;
          end
        end
      end
      in_code   = 1'b1;
      code_live = '1;
      code_len  = '0;
    end else if (u > etm_pkg::ASCII_MAX || (in_code && code_len >= CODE_MAX)) begin
      in_code   = 1'b0;
      code_live = '0;
      code_len  = '0;
    end else if (in_code) begin
      keep = '0;
      for (int i = 0; i < N_SYM; i++) begin
        if (code_live[i] && int'(code_len) < sym_label[i].len()
            && 8'(sym_label[i].getc(code_len)) == u[7:0]) keep[i] = 1'b1;
      end
      code_live = keep;
      code_len  = code_len + etm_pkg::CNT_W'(1);
    end
    hit_seen    = hit_seen | r.matched;
    r.any_match = hit_seen;
    if (fin) clear_text();
  endtask

  task automatic check_field(string fname, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
    end
  endtask

  // driver: offers the head of unit_q, predicts each accepted request
  always @(posedge clk_i or negedge rst_ni) begin : tx_side
    etm_pkg::result_t pred;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      code_unit_i <= '0;
      text_end_i  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        scan_unit(code_unit_i, text_end_i, pred);
        match_q.push_back(pred);
        void'(unit_q.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        if (unit_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          code_unit_i <= unit_q[0].unit;
          text_end_i  <= unit_q[0].fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results, drives out_ready_i
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    etm_pkg::result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (match_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected, actual matched=%0d index=%0d len=%0d",
                   $time, matched_o, entry_index_o, match_length_o);
        end else begin
          want = match_q.pop_front();
          check_field("matched", want.matched, matched_o);
          check_field("entry_index", want.entry_index, entry_index_o);
          check_field("match_length", want.match_length, match_length_o);
          check_field("any_match", want.any_match, any_match_o);
          check_field("ends_text", want.ends_text, ends_text_o);
        end
      end
      if (freeze_seen != freeze_req) begin
        freeze_seen = freeze_req;
        freeze_left = FREEZE_LEN;
      end
      if (freeze_left > 0) begin
        freeze_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put(logic [etm_pkg::UNIT_W-1:0] u);
    text_buf.push_back('{u, 1'b0});
  endtask

  task automatic put_pair(logic [20:0] cp);
    logic [20:0] off;
    off = cp - etm_pkg::SUPP_BASE;
    put(etm_pkg::HI_SUR_MIN | etm_pkg::UNIT_W'(off[19:10]));
    put(etm_pkg::LO_SUR_MIN | etm_pkg::UNIT_W'(off[9:0]));
  endtask

  task automatic flush_text(logic mark_end);
    text_req_t last;
    if (mark_end && text_buf.size() > 0) begin
      last = text_buf.pop_back();
      last.fin = 1'b1;
      text_buf.push_back(last);
    end
    foreach (text_buf[i]) unit_q.push_back(text_buf[i]);
    sent_cnt += text_buf.size();
    text_buf.delete();
  endtask

  // sender pause: nothing new until every request has come back
  task automatic drain();
    while (unit_q.size() > 0 || match_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_mask(etm_pkg::entry_vec_t v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    mask_shadow = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic gen_text();
    int    n_tok;
    int    k;
    int    pick;
    int    bad_at;
    string lbl;
    n_tok = $urandom_range(1, 6);
    repeat (n_tok) begin
      k      = $urandom_range(99);
      pick   = $urandom_range(N_SYM - 1);
      bad_at = -1;
      if (k < 40) begin
        lbl = sym_label[pick];
        case ($urandom_range(9))
          7: begin
            if (lbl.len() > 1) lbl = lbl.substr(0, $urandom_range(0, lbl.len() - 2));
          end
          8: begin
            lbl.putc($urandom_range(lbl.len() - 1), byte'($urandom_range(33, 126)));
          end
          9: begin
            bad_at = $urandom_range(lbl.len() - 1);
          end
          default: ;
        endcase
        put(etm_pkg::UNIT_COLON);
        for (int j = 0; j < lbl.len(); j++) begin
          if (j == bad_at) put(etm_pkg::UNIT_W'($urandom_range(16'h0080, 16'hFFFF)));
          put(etm_pkg::UNIT_W'(lbl.getc(j)));
        end
        if ($urandom_range(9) != 0) put(etm_pkg::UNIT_COLON);
      end else if (k < 55) begin
        if (sym_point[pick] < etm_pkg::SUPP_BASE) put(etm_pkg::UNIT_W'(sym_point[pick]));
        else put_pair(sym_point[pick]);
      end else if (k < 60) begin
        put(etm_pkg::UNIT_W'(sym_point[bmp_pick[$urandom_range(3)]]));
      end else if (k < 75) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1)) put(etm_pkg::UNIT_W'($urandom_range(16'h61, 16'h7A)));
          else put(etm_pkg::UNIT_W'($urandom_range(16'h01, 16'h7F)));
        end
      end else if (k < 80) begin
        // names around the length limit
        put(etm_pkg::UNIT_COLON);
        repeat ($urandom_range(CODE_MAX - 2, CODE_MAX + 3))
          put(etm_pkg::UNIT_W'($urandom_range(16'h61, 16'h7A)));
        put(etm_pkg::UNIT_COLON);
      end else if (k < 90) begin
        repeat ($urandom_range(1, 3)) put(etm_pkg::UNIT_W'($urandom_range(16'hFFFF)));
      end else if (k < 95) begin
        case ($urandom_range(2))
          0: begin
            put(etm_pkg::UNIT_W'($urandom_range(etm_pkg::HI_SUR_MIN, etm_pkg::HI_SUR_MAX)));
            put(etm_pkg::UNIT_W'($urandom_range(16'h01, 16'h7F)));
          end
          1: begin
            put(etm_pkg::UNIT_W'($urandom_range(etm_pkg::LO_SUR_MIN, etm_pkg::LO_SUR_MAX)));
          end
          default: begin
            put(etm_pkg::UNIT_W'($urandom_range(etm_pkg::HI_SUR_MIN, etm_pkg::HI_SUR_MAX)));
            put(etm_pkg::UNIT_W'($urandom_range(etm_pkg::HI_SUR_MIN, etm_pkg::HI_SUR_MAX)));
            put(etm_pkg::UNIT_W'($urandom_range(etm_pkg::LO_SUR_MIN, etm_pkg::LO_SUR_MAX)));
          end
        endcase
      end else if (k < 98) begin
        put(etm_pkg::UNIT_NUL);
      end else begin
        put(etm_pkg::UNIT_COLON);
      end
    end
    flush_text($urandom_range(4) != 0);
  endtask

  task automatic run_phase(int n_items);
    int target;
    target = sent_cnt + n_items;
    while (sent_cnt < target) begin
      @(negedge clk_i);
      gen_text();
      if ($urandom_range(39) == 0) drain();
      while (unit_q.size() > 16) @(negedge clk_i);
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: BMP hit, pairs, lone and replaced surrogates, shortcodes,
    // empty name, non-ASCII kill, extreme units, zero unit, text end
    put(16'h2764);
    put(16'hD83D); put(16'hDE00);
    put(16'hDE00);
    put(16'hD83D); put(16'hD83C); put(16'hDFAE);
    put(16'hD83D); put(16'h0061);
    put(etm_pkg::UNIT_COLON); put(16'h006A); put(16'h006F); put(16'h0079);
    put(etm_pkg::UNIT_COLON);
    put(etm_pkg::UNIT_COLON); put(16'h0078); put(etm_pkg::UNIT_COLON);
    put(etm_pkg::UNIT_COLON); put(16'h006A); put(16'h00E9); put(etm_pkg::UNIT_COLON);
    put(16'hFFFF);
    put(etm_pkg::UNIT_NUL);
    put(16'h26A0);
    flush_text(1'b1);
    drain();

    write_mask('0);
    run_phase(40);
    drain();

    write_mask(etm_pkg::entry_vec_t'({$urandom, $urandom}));
    send_idle_pct = 21;
    recv_idle_pct = 86;
    run_phase(340);
    drain();

    write_mask('1);
    send_idle_pct = 86;
    recv_idle_pct = 21;
    run_phase(340);
    drain();

    write_mask(etm_pkg::entry_vec_t'(42'h155_5555_5555));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk_i);
    freeze_req++;
    run_phase(340);
    drain();

    repeat (6) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
design/etm_pkg.sv
design/emoji_token_matcher.sv
verif/tb_top.sv
